// ----- src/emb_pkg.sv -----
// Shared types and constants for the 3x3 emboss gray filter.
// No dependencies; imported by every module of the block.
package emb_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int DATA_W        = 24;
    localparam int SUM_W         = 10;
    localparam int GRAY_W        = 8;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 13;
    localparam int RESET_WIDTH   = 1024;
    localparam int RESET_HEIGHT  = 1024;
    localparam int ROUND_BIAS    = 384;
    localparam int RECIP_3       = 683;
    localparam int RECIP_SHIFT   = 11;
    localparam int CLAMP_LIMIT   = 765;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 8'd0,
        REG_IMAGE_HEIGHT = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic emit;
        logic use2;
        logic last;
    } pix_ctrl_t;

endpackage

// ----- src/emb_scan.sv -----
// Scan position, frame geometry registers and line store pointer.
// Depends on emb_pkg.
module emb_scan import emb_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int PTR_W     = $clog2(MAX_WIDTH + 2)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  adv,
    input  logic [DATA_W-1:0]     pix,
    output logic [SUM_W-1:0]      cur,
    output pix_ctrl_t             ctrl,
    output logic [PTR_W-1:0]      ptr
);

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int RST_W  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic [COL_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [WIDTH_W-1:0]  wr_width;
    logic [HEIGHT_W-1:0] wr_height;
    logic                pad;

    assign cfg_ready = 1'b1;
    assign wr_width  = cfg_data[WIDTH_W-1:0];
    assign wr_height = cfg_data[HEIGHT_W-1:0];

    assign pad  = (col_reg >= width_reg) || (row_reg >= height_reg);
    assign cur  = pad ? '0 : SUM_W'(pix[7:0]) + SUM_W'(pix[15:8]) + SUM_W'(pix[23:16]);
    assign ptr  = ptr_reg;

    assign ctrl.emit = (col_reg != '0) && (row_reg != '0);
    assign ctrl.use2 = (col_reg >= COL_W'(2)) && (row_reg >= HEIGHT_W'(2));
    assign ctrl.last = (col_reg == width_reg) && (row_reg == height_reg);

    always_comb begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        ptr_next = (ptr_reg == PTR_W'(width_reg) + PTR_W'(1)) ? '0 : ptr_reg + PTR_W'(1);
        if (col_reg == width_reg) begin
            col_next = '0;
            row_next = (row_reg == height_reg) ? '0 : row_reg + HEIGHT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= COL_W'(RST_W);
            height_reg <= HEIGHT_W'(RESET_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
            ptr_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    if (wr_width == '0) begin
                        width_reg <= COL_W'(1);
                    end else if (int'(wr_width) > MAX_WIDTH) begin
                        width_reg <= COL_W'(MAX_WIDTH);
                    end else begin
                        width_reg <= COL_W'(wr_width);
                    end
                    col_reg <= '0;
                    row_reg <= '0;
                    ptr_reg <= '0;
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg <= (wr_height == '0) ? HEIGHT_W'(1) : wr_height;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    ptr_reg    <= '0;
                end
                default: begin
                end
            endcase
        end else if (adv) begin
            col_reg <= col_next;
            row_reg <= row_next;
            ptr_reg <= ptr_next;
        end
    end

endmodule

// ----- src/emb_line.sv -----
// Two chained line stores giving the sums one and two diagonal steps back.
// Depends on emb_pkg.
module emb_line import emb_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int PTR_W     = $clog2(MAX_WIDTH + 2)
) (
    input  logic             aclk,
    input  logic             adv,
    input  logic [PTR_W-1:0] ptr,
    input  logic [SUM_W-1:0] cur,
    output logic [SUM_W-1:0] ul1,
    output logic [SUM_W-1:0] ul2
);

    localparam int DEPTH = MAX_WIDTH + 2;

    logic [SUM_W-1:0] mem1 [DEPTH];
    logic [SUM_W-1:0] mem2 [DEPTH];
    logic [SUM_W-1:0] rd1_reg;
    logic [SUM_W-1:0] rd2_reg;
    logic [PTR_W-1:0] wptr2_reg;

    assign ul1 = rd1_reg;
    assign ul2 = rd2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd1_reg   <= mem1[ptr];
            mem1[ptr] <= cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd2_reg         <= mem2[ptr];
            mem2[wptr2_reg] <= rd1_reg;
            wptr2_reg       <= ptr;
        end
    end

endmodule

// ----- src/emb_calc.sv -----
// Emboss arithmetic stage and output register with flow control.
// Depends on emb_pkg.
module emb_calc import emb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [SUM_W-1:0]  cur,
    input  pix_ctrl_t         ctrl,
    input  logic [SUM_W-1:0]  ul1,
    input  logic [SUM_W-1:0]  ul2,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [GRAY_W-1:0] gray,
    output logic              frame_end
);

    localparam int T_W = 12;

    logic              b_vld_reg;
    logic [SUM_W-1:0]  b_cur_reg;
    pix_ctrl_t         b_ctrl_reg;
    logic              m_vld_reg;
    logic [GRAY_W-1:0] gray_reg, gray_next;
    logic              last_reg;
    logic              b_move;
    logic signed [T_W-1:0] t;
    logic [SUM_W-1:0]  ul2_sel;
    logic [19:0]       prod;

    assign b_move   = b_vld_reg && (!b_ctrl_reg.emit || !m_vld_reg || m_tready);
    assign s_tready = !b_vld_reg || b_move;
    assign m_tvalid = m_vld_reg;
    assign gray     = gray_reg;
    assign frame_end = last_reg;

    assign ul2_sel = b_ctrl_reg.use2 ? ul2 : '0;
    assign t = $signed({1'b0, b_cur_reg, 1'b0}) - $signed({2'b00, ul1})
             - $signed({2'b00, ul2_sel}) + T_W'(ROUND_BIAS);
    assign prod = 20'(t[9:0]) * 20'(RECIP_3);

    always_comb begin
        if (t < 0) begin
            gray_next = '0;
        end else if (t >= T_W'(CLAMP_LIMIT)) begin
            gray_next = '1;
        end else begin
            gray_next = prod[RECIP_SHIFT +: GRAY_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else begin
            if (adv) begin
                b_vld_reg <= 1'b1;
            end else if (b_move) begin
                b_vld_reg <= 1'b0;
            end
            if (b_move && b_ctrl_reg.emit) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_cur_reg  <= cur;
            b_ctrl_reg <= ctrl;
        end
        if (b_move && b_ctrl_reg.emit) begin
            gray_reg <= gray_next;
            last_reg <= b_ctrl_reg.last;
        end
    end

endmodule

// ----- src/emboss_filter_3x3_gray.sv -----
// 3x3 emboss filter producing one 8-bit gray level per RGB pixel of a padded
// raster frame. Takes one pixel transfer per clock unless the input stalls. A pixel
// is registered together with its two line store reads, and its result is registered
// in the output register once that register can take it. Each line store does one
// read and one write per pixel. Input stalls only while a result waits untaken at
// the output and the pixel behind it also has a result.
// Writing either geometry register restarts the frame at its first pixel.
// Depends on emb_pkg, emb_scan, emb_line and emb_calc.
module emboss_filter_3x3_gray import emb_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [GRAY_W-1:0]     m_tdata,   // gray[7:0]
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W = $clog2(MAX_WIDTH + 2);

    logic             adv;
    logic [SUM_W-1:0] cur;
    logic [SUM_W-1:0] ul1;
    logic [SUM_W-1:0] ul2;
    logic [PTR_W-1:0] ptr;
    pix_ctrl_t        ctrl;

    assign adv = s_tvalid && s_tready;

    emb_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .PTR_W     (PTR_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .adv       (adv),
        .pix       (s_tdata),
        .cur       (cur),
        .ctrl      (ctrl),
        .ptr       (ptr)
    );

    emb_line #(
        .MAX_WIDTH (MAX_WIDTH),
        .PTR_W     (PTR_W)
    ) u_line (
        .aclk (aclk),
        .adv  (adv),
        .ptr  (ptr),
        .cur  (cur),
        .ul1  (ul1),
        .ul2  (ul2)
    );

    emb_calc u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cur       (cur),
        .ctrl      (ctrl),
        .ul1       (ul1),
        .ul2       (ul2),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .gray      (m_tdata),
        .frame_end (m_tlast)
    );

endmodule

// ----- src/emb_check.sv -----
// Port-level checker for the emboss filter, bound to the top level.
// Depends on emb_pkg.
module emb_check import emb_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [GRAY_W-1:0]     m_tdata,
    input logic                  m_tlast,
    input logic                  cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_rose_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching input transfer");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind emboss_filter_3x3_gray emb_check u_check (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

// ----- tb/sv/emboss_filter_3x3_gray_test.sv -----
// Self-checking bench for emboss_filter_3x3_gray: padded RGB raster frames in,
// embossed gray levels out, checked against an in-bench emboss predictor.
// Depends on emb_pkg and the emboss_filter_3x3_gray RTL.
module emboss_filter_3x3_gray_test;
    import emb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_MAX_WIDTH  = 1024;
    localparam int HISTORY_DEPTH  = 2 * (PIX_MAX_WIDTH + 2);
    localparam int EMBOSS_BIAS    = 384;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PIXELS  = 240;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic       last;
        logic [7:0] gray;
    } emboss_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [GRAY_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    emboss_filter_3x3_gray #(
        .MAX_WIDTH(PIX_MAX_WIDTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // emboss predictor state
    logic [SUM_W-1:0]    sum_history [HISTORY_DEPTH] = '{default: '0};
    int unsigned         history_wr = 0;
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;
    logic [WIDTH_W-1:0]  width_reg = 11'd1024;
    logic [HEIGHT_W-1:0] height_reg = 13'd1024;

    emboss_result_t gray_expect[$];
    int             mismatch_count = 0;
    int             pixels_sent = 0;
    int             idle_cycles = 0;
    bit             idling_on = 1'b1;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int eff_width(input int raw);
        if (raw == 0) return 1;
        if (raw > PIX_MAX_WIDTH) return PIX_MAX_WIDTH;
        return raw;
    endfunction

    function automatic void apply_geometry_write(input logic [CFG_IDX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg = data[WIDTH_W-1:0];
        end else if (idx == REG_IMAGE_HEIGHT) begin
            height_reg = data[HEIGHT_W-1:0];
        end else begin
            return;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic bit emboss_step(input rgb_t px, output emboss_result_t res);
        int unsigned w, h, lag;
        int          cur, ul1, ul2, t;
        bit          emit;
        w = eff_width(int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        lag = w + 2;
        if (col_pos >= w || row_pos >= h)
            cur = 0;
        else
            cur = int'(px.red) + int'(px.green) + int'(px.blue);
        ul1 = 0;
        ul2 = 0;
        if (col_pos >= 1 && row_pos >= 1)
            ul1 = int'(sum_history[(history_wr + HISTORY_DEPTH - lag) % HISTORY_DEPTH]);
        if (col_pos >= 2 && row_pos >= 2)
            ul2 = int'(sum_history[(history_wr + HISTORY_DEPTH - 2 * lag) % HISTORY_DEPTH]);
        sum_history[history_wr] = cur[SUM_W-1:0];
        history_wr = (history_wr + 1) % HISTORY_DEPTH;
        emit = (col_pos >= 1 && row_pos >= 1);
        res = '0;
        if (emit) begin
            t = 2 * cur - ul1 - ul2 + EMBOSS_BIAS;
            if (t < 0)
                res.gray = 8'd0;
            else if (t / 3 > 255)
                res.gray = 8'd255;
            else
                res.gray = 8'(t / 3);
            res.last = (col_pos == w && row_pos == h);
        end
        col_pos++;
        if (col_pos > w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos > h) row_pos = 0;
        end
        return emit;
    endfunction

    // predict on input transfers, check on output transfers
    always @(posedge aclk) begin
        emboss_result_t predicted, wanted, seen;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) apply_geometry_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                if (emboss_step(rgb_t'(s_tdata), predicted)) gray_expect.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                seen = {m_tlast, m_tdata};
                if (gray_expect.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: gray=%0d last=%b", seen.gray, seen.last);
                end else begin
                    wanted = gray_expect.pop_front();
                    if (seen.gray !== wanted.gray || seen.last !== wanted.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: expected gray=%0d last=%b, got gray=%0d last=%b",
                                     wanted.gray, wanted.last, seen.gray, seen.last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL emboss_filter_3x3_gray");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready = idling_on ? ($urandom_range(0, 99) >= 24) : 1'b1;
    end

    function automatic rgb_t random_rgb();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) return '1;
        if (pick < 22) return '0;
        return rgb_t'($urandom());
    endfunction

    task automatic send_pixel(input rgb_t px);
        while (idling_on && $urandom_range(0, 99) < 24) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = px;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic send_raster(input int w, input int h, input int first, input int count,
                               input bit zero_pad);
        int   col, row;
        rgb_t px;
        for (int i = first; i < first + count; i++) begin
            col = i % (w + 1);
            row = (i / (w + 1)) % (h + 1);
            px = random_rgb();
            if (zero_pad && (col == w || row == h)) px = '0;
            send_pixel(px);
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (gray_expect.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_data,
                                input logic [CFG_DATA_W-1:0] h_data);
        write_reg(REG_IMAGE_WIDTH, w_data);
        write_reg(REG_IMAGE_HEIGHT, h_data);
    endtask

    task automatic write_unused_index();
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom()));
    endtask

    task automatic test_degenerate_sizes();
        set_geometry(16'hF800, 16'hE000);
        send_raster(1, 1, 0, 8, 1'b0);
        set_geometry(16'd1, 16'd1);
        send_raster(1, 1, 0, 4, 1'b1);
    endtask

    task automatic test_extreme_levels();
        set_geometry(16'd2, 16'd2);
        repeat (9) send_pixel('1);
    endtask

    task automatic test_unused_index();
        set_geometry(16'd3, 16'd2);
        send_raster(3, 2, 0, 6, 1'b1);
        write_unused_index();
        send_raster(3, 2, 6, 6, 1'b1);
    endtask

    task automatic test_restart_mid_frame();
        set_geometry(16'd5, 16'd4);
        send_raster(5, 4, 0, 17, 1'b0);
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        send_raster(5, 4, 0, 30, 1'b0);
    endtask

    task automatic test_reset_geometry();
        wait_drained();
        send_raster(1024, 1024, 0, 1025 + 3, 1'b1);
    endtask

    task automatic test_width_saturation();
        idling_on = 1'b0;
        set_geometry(16'hFFFF, 16'd1);
        send_raster(1024, 1, 0, 1025 + 3, 1'b0);
        idling_on = 1'b1;
    endtask

    task automatic test_tall_frames();
        set_geometry(16'd1, 16'hFFFF);
        send_raster(1, 8191, 0, 32, 1'b0);
        set_geometry(16'd1, 16'd4096);
        send_raster(1, 4096, 0, 32, 1'b1);
    endtask

    task automatic test_random_frames();
        int target, w_raw, h_raw, w, h, frame_len, part;
        bit zero_pad;
        target = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < target) begin
            w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            if ($urandom_range(0, 19) == 0) w_raw = 0;
            if ($urandom_range(0, 19) == 0) h_raw = 0;
            w = eff_width(w_raw);
            h = (h_raw == 0) ? 1 : h_raw;
            idling_on = ($urandom_range(0, 4) != 0);
            set_geometry({5'($urandom()), 11'(w_raw)}, {3'($urandom()), 13'(h_raw)});
            frame_len = (w + 1) * (h + 1);
            zero_pad = $urandom_range(0, 1);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0) begin
                    part = $urandom_range(1, frame_len - 1);
                    send_raster(w, h, 0, part, zero_pad);
                    if ($urandom_range(0, 1) == 0) begin
                        write_unused_index();
                        send_raster(w, h, part, frame_len - part, zero_pad);
                    end
                    break;
                end
                send_raster(w, h, 0, frame_len, zero_pad);
            end
        end
        idling_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_geometry();
        test_degenerate_sizes();
        test_extreme_levels();
        test_unused_index();
        test_restart_mid_frame();
        test_width_saturation();
        test_tall_frames();
        test_random_frames();
        wait_drained();
        if (mismatch_count == 0 && gray_expect.size() == 0)
            $display("PASS emboss_filter_3x3_gray");
        else
            $display("FAIL emboss_filter_3x3_gray");
        $finish;
    end

endmodule
